@@ design/rpr_pkg.sv @@
// ----------------------------------------------------------------------------
// rpr_pkg: shared types and constants of the retarding principal rate block.
// Holds the transaction payload structs, the register map and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package rpr_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int EIG_FRAC_BITS = 14;
	localparam int DATA_W        = 32;
	localparam int EIG_W         = 16;
	localparam int EIG_ROW_W     = 3 * EIG_W;
	localparam int NUM_STAGES    = 12;
	localparam int PADDR_W       = 3;

	localparam logic signed [DATA_W-1:0] ALPHA_RESET = DATA_W'(1 << FRAC_BITS);
	localparam logic signed [DATA_W-1:0] BETA_RESET  = '0;

	localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_MIN = -(64'sd1 <<< (DATA_W - 1));

	typedef enum logic {
		REG_ALPHA_GAIN  = 1'b0,
		REG_BETA_WEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rate_xx;
		logic signed [DATA_W-1:0] rate_xy;
		logic signed [DATA_W-1:0] rate_xz;
		logic signed [DATA_W-1:0] rate_yy;
		logic signed [DATA_W-1:0] rate_yz;
		logic signed [DATA_W-1:0] rate_zz;
		logic [EIG_ROW_W-1:0]     eigvec_row_x;
		logic [EIG_ROW_W-1:0]     eigvec_row_y;
		logic [EIG_ROW_W-1:0]     eigvec_row_z;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] retarded_xx;
		logic signed [DATA_W-1:0] retarded_xy;
		logic signed [DATA_W-1:0] retarded_xz;
		logic signed [DATA_W-1:0] retarded_yy;
		logic signed [DATA_W-1:0] retarded_yz;
		logic signed [DATA_W-1:0] retarded_zz;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] alpha_gain;
		logic signed [DATA_W-1:0] beta_weight;
	} cfg_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[DATA_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/rpr_cfg.sv @@
// ----------------------------------------------------------------------------
// rpr_cfg: configuration register file behind the APB-style port.
// Holds the alpha gain and the beta weight and returns them on reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_cfg
	import rpr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_gain  <= ALPHA_RESET;
			cfg_q.beta_weight <= BETA_RESET;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_ALPHA_GAIN:  cfg_q.alpha_gain  <= pwdata;
				REG_BETA_WEIGHT: cfg_q.beta_weight <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ALPHA_GAIN:  prdata = cfg_q.alpha_gain;
			REG_BETA_WEIGHT: prdata = cfg_q.beta_weight;
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ design/principal_rate_retarding_tensor.sv @@
// ----------------------------------------------------------------------------
// principal_rate_retarding_tensor: IOK retarding principal rate for one mesh cell.
// Twelve register stages; a result is valid once its transaction has passed all twelve.
// Throughput is one item per cycle unless stalled; a stall holds only the full stages.
// Reset clears the stage valid bits and sets alpha_gain to 1.0 and beta_weight to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module principal_rate_retarding_tensor
	import rpr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire item_t              item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output result_t                 result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready
);

	localparam int M1_W   = DATA_W + EIG_W;
	localparam int T_W    = M1_W + 3 - EIG_FRAC_BITS;
	localparam int M2_W   = T_W + EIG_W;
	localparam int SQ_W   = 2 * DATA_W;
	localparam int QR_W   = SQ_W + 1 - FRAC_BITS;
	localparam int QS_W   = QR_W + 2;
	localparam int D_W    = QR_W + 1;
	localparam int WP_W   = 2 * EIG_W + 1;
	localparam int W_W    = WP_W - EIG_FRAC_BITS;
	localparam int M3_W   = DATA_W + W_W;
	localparam int O_W    = M3_W + 3 - EIG_FRAC_BITS;
	localparam int HALF_E = 1 << (EIG_FRAC_BITS - 1);
	localparam int HALF_F = 1 << (FRAC_BITS - 1);
	localparam int OI [6] = '{0, 0, 0, 1, 1, 2};
	localparam int OJ [6] = '{0, 1, 2, 1, 2, 2};

	cfg_t cfg;

	rpr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] adv;

	logic signed [DATA_W-1:0] rmat   [3][3];
	logic signed [EIG_W-1:0]  eig_in [3][3];

	logic signed [M1_W-1:0]   m1_s1  [3][3][3];
	logic signed [EIG_W-1:0]  eig_s1 [3][3];
	logic signed [T_W-1:0]    t_s2   [3][3];
	logic signed [EIG_W-1:0]  eig_s2 [3][3];
	logic signed [M2_W-1:0]   m2_s3  [3][3];
	logic signed [EIG_W-1:0]  eig_s3 [3][3];
	logic signed [DATA_W-1:0] p_s4   [3];
	logic signed [EIG_W-1:0]  eig_s4 [3][3];
	logic signed [SQ_W-1:0]   sq_s5  [3];
	logic signed [SQ_W-1:0]   cr_s5  [3];
	logic signed [DATA_W-1:0] pk_s5  [3];
	logic signed [EIG_W-1:0]  eig_s5 [3][3];
	logic signed [DATA_W-1:0] q_s6   [3];
	logic signed [DATA_W-1:0] pk_s6  [3];
	logic signed [EIG_W-1:0]  eig_s6 [3][3];
	logic signed [SQ_W-1:0]   bq_s7  [3];
	logic signed [DATA_W-1:0] pk_s7  [3];
	logic signed [EIG_W-1:0]  eig_s7 [3][3];
	logic signed [DATA_W-1:0] d_s8   [3];
	logic signed [EIG_W-1:0]  eig_s8 [3][3];
	logic signed [SQ_W-1:0]   ad_s9  [3];
	logic signed [EIG_W-1:0]  eig_s9 [3][3];
	logic signed [DATA_W-1:0] lam_s10 [3];
	logic signed [W_W-1:0]    w_s10   [3][6];
	logic signed [M3_W-1:0]   m3_s11  [6][3];
	logic signed [DATA_W-1:0] res_s12 [6];

	logic signed [T_W-1:0]    t_nxt   [3][3];
	logic signed [DATA_W-1:0] p_nxt   [3];
	logic signed [DATA_W-1:0] q_nxt   [3];
	logic signed [DATA_W-1:0] d_nxt   [3];
	logic signed [DATA_W-1:0] lam_nxt [3];
	logic signed [W_W-1:0]    w_nxt   [3][6];
	logic signed [DATA_W-1:0] res_nxt [6];

	// Principal 0 uses the z row, principal 2 the x row.
	always_comb begin
		rmat[0][0] = item.rate_xx;
		rmat[0][1] = item.rate_xy;
		rmat[0][2] = item.rate_xz;
		rmat[1][0] = item.rate_xy;
		rmat[1][1] = item.rate_yy;
		rmat[1][2] = item.rate_yz;
		rmat[2][0] = item.rate_xz;
		rmat[2][1] = item.rate_yz;
		rmat[2][2] = item.rate_zz;
		for (int c = 0; c < 3; c++) begin
			eig_in[0][c] = item.eigvec_row_z[EIG_W*c +: EIG_W];
			eig_in[1][c] = item.eigvec_row_y[EIG_W*c +: EIG_W];
			eig_in[2][c] = item.eigvec_row_x[EIG_W*c +: EIG_W];
		end
	end

	always_comb begin
		adv[NUM_STAGES] = !vld_q[NUM_STAGES] || result_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign item_ready   = adv[1];
	assign result_valid = vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= item_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		logic signed [M1_W+2:0] tsum;
		logic signed [M2_W+2:0] psum;
		logic signed [SQ_W:0]   sq_x;
		logic signed [SQ_W:0]   cr_x;
		logic signed [SQ_W:0]   bq_x;
		logic signed [SQ_W:0]   ad_x;
		logic signed [QS_W-1:0] qsum;
		logic signed [D_W-1:0]  dsum;
		logic signed [WP_W-1:0] ww;
		logic signed [M3_W+2:0] osum;
		logic signed [O_W:0]    oneg;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				tsum = (M1_W+3)'(m1_s1[k][i][0]) + (M1_W+3)'(m1_s1[k][i][1])
					+ (M1_W+3)'(m1_s1[k][i][2]) + (M1_W+3)'(HALF_E);
				t_nxt[k][i] = tsum[M1_W+2:EIG_FRAC_BITS];
			end
			psum = (M2_W+3)'(m2_s3[k][0]) + (M2_W+3)'(m2_s3[k][1])
				+ (M2_W+3)'(m2_s3[k][2]) + (M2_W+3)'(HALF_E);
			p_nxt[k] = sat32(64'($signed(psum[M2_W+2:EIG_FRAC_BITS])));

			sq_x = (SQ_W+1)'(sq_s5[k]) + (SQ_W+1)'(HALF_F);
			cr_x = (SQ_W+1)'(cr_s5[k]) + (SQ_W+1)'(HALF_F);
			qsum = QS_W'($signed(sq_x[SQ_W:FRAC_BITS]))
				+ (QS_W'($signed(cr_x[SQ_W:FRAC_BITS])) <<< 1);
			q_nxt[k] = sat32(64'(qsum));

			bq_x = (SQ_W+1)'(bq_s7[k]) + (SQ_W+1)'(HALF_F);
			dsum = D_W'(pk_s7[k]) - D_W'($signed(bq_x[SQ_W:FRAC_BITS]));
			d_nxt[k] = sat32(64'(dsum));

			ad_x = (SQ_W+1)'(ad_s9[k]) + (SQ_W+1)'(HALF_F);
			lam_nxt[k] = sat32(64'($signed(ad_x[SQ_W:FRAC_BITS])));

			for (int o = 0; o < 6; o++) begin
				ww = WP_W'(eig_s9[k][OI[o]]) * WP_W'(eig_s9[k][OJ[o]]) + WP_W'(HALF_E);
				w_nxt[k][o] = ww[WP_W-1:EIG_FRAC_BITS];
			end
		end
		for (int o = 0; o < 6; o++) begin
			osum = (M3_W+3)'(m3_s11[o][0]) + (M3_W+3)'(m3_s11[o][1])
				+ (M3_W+3)'(m3_s11[o][2]) + (M3_W+3)'(HALF_E);
			oneg = -(O_W+1)'($signed(osum[M3_W+2:EIG_FRAC_BITS]));
			res_nxt[o] = sat32(64'(oneg));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						m1_s1[k][i][j] <= M1_W'(rmat[i][j]) * M1_W'(eig_in[k][j]);
					end
				end
			end
			eig_s1 <= eig_in;
		end
		if (adv[2]) begin
			t_s2   <= t_nxt;
			eig_s2 <= eig_s1;
		end
		if (adv[3]) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					m2_s3[k][i] <= M2_W'(t_s2[k][i]) * M2_W'(eig_s2[k][i]);
				end
			end
			eig_s3 <= eig_s2;
		end
		if (adv[4]) begin
			p_s4   <= p_nxt;
			eig_s4 <= eig_s3;
		end
		if (adv[5]) begin
			for (int k = 0; k < 3; k++) begin
				sq_s5[k] <= SQ_W'(p_s4[k]) * SQ_W'(p_s4[k]);
			end
			cr_s5[0] <= SQ_W'(p_s4[1]) * SQ_W'(p_s4[2]);
			cr_s5[1] <= SQ_W'(p_s4[2]) * SQ_W'(p_s4[0]);
			cr_s5[2] <= SQ_W'(p_s4[0]) * SQ_W'(p_s4[1]);
			pk_s5  <= p_s4;
			eig_s5 <= eig_s4;
		end
		if (adv[6]) begin
			q_s6   <= q_nxt;
			pk_s6  <= pk_s5;
			eig_s6 <= eig_s5;
		end
		if (adv[7]) begin
			for (int k = 0; k < 3; k++) begin
				bq_s7[k] <= SQ_W'(cfg.beta_weight) * SQ_W'(q_s6[k]);
			end
			pk_s7  <= pk_s6;
			eig_s7 <= eig_s6;
		end
		if (adv[8]) begin
			d_s8   <= d_nxt;
			eig_s8 <= eig_s7;
		end
		if (adv[9]) begin
			for (int k = 0; k < 3; k++) begin
				ad_s9[k] <= SQ_W'(cfg.alpha_gain) * SQ_W'(d_s8[k]);
			end
			eig_s9 <= eig_s8;
		end
		if (adv[10]) begin
			lam_s10 <= lam_nxt;
			w_s10   <= w_nxt;
		end
		if (adv[11]) begin
			for (int o = 0; o < 6; o++) begin
				for (int k = 0; k < 3; k++) begin
					m3_s11[o][k] <= M3_W'(lam_s10[k]) * M3_W'(w_s10[k][o]);
				end
			end
		end
		if (adv[12]) begin
			res_s12 <= res_nxt;
		end
	end

	assign result.retarded_xx = res_s12[0];
	assign result.retarded_xy = res_s12[1];
	assign result.retarded_xz = res_s12[2];
	assign result.retarded_yy = res_s12[3];
	assign result.retarded_yz = res_s12[4];
	assign result.retarded_zz = res_s12[5];

`ifndef SYNTHESIS
	ap_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> vld_q[1])
		else $error("Accepted transaction did not enter the first stage.");

	ap_no_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> item_ready)
		else $error("Input blocked while the output is not stalled.");

	ap_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("Input blocked while no result is waiting.");

	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		arst_n |=> ($countones(vld_q) == $past($countones(vld_q))
			+ int'($past(item_valid && item_ready))
			- int'($past(result_valid && result_ready))))
		else $error("Pipeline lost or duplicated a transaction.");
`endif

endmodule

`default_nettype wire
